@@ rtl/tat_pkg.sv @@
// tat_pkg: types and constants of the image hash allowlist table
// used by tat_ram-free logic in trust_allowlist_table_core; no dependencies
package tat_pkg;

    localparam int TAT_TABLE_DEPTH = 256;

    // operation codes
    localparam logic [1:0] FUNC_CHECK    = 2'd0;
    localparam logic [1:0] FUNC_REGISTER = 2'd1;
    localparam logic [1:0] FUNC_REVOKE   = 2'd2;
    localparam logic [1:0] FUNC_LOOKUP   = 2'd3;

    // trust levels
    localparam logic [1:0] LVL_SYSTEM    = 2'd0;
    localparam logic [1:0] LVL_DEVELOPER = 2'd1;
    localparam logic [1:0] LVL_UNTRUSTED = 2'd2;
    localparam logic [1:0] LVL_REVOKED   = 2'd3;

    // enforcement modes
    localparam logic [1:0] MODE_DISABLED = 2'd0;
    localparam logic [1:0] MODE_AUDIT    = 2'd1;
    localparam logic [1:0] MODE_ENFORCE  = 2'd2;

    // result status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_FULL      = 2'd1;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic [1:0]  func;
        logic [63:0] key_word0;
        logic [63:0] key_word1;
        logic [63:0] key_word2;
        logic [63:0] key_word3;
        logic [1:0]  trust_in;
        logic [31:0] flags_in;
        logic        image_empty;
    } t_cmd;

    typedef struct packed {
        logic        valid_res;
        logic [1:0]  trust_out;
        logic [31:0] flags_out;
        logic        trusted;
        logic [1:0]  status;
        logic [31:0] checks_done;
        logic [31:0] denials;
    } t_res;

    // one table slot as held in memory
    typedef struct packed {
        logic [255:0] key;
        logic [1:0]   trust;
        logic [31:0]  flags;
    } t_entry;

endpackage

@@ rtl/trust_allowlist_table_core.sv @@
// trust_allowlist_table_core: allowlist of 256-bit image hashes with trust and flags
// depends on tat_pkg and tat_ram
// sequence: accept in idle, scan up to N = slots filled (<= TABLE_DEPTH) in order, stopping
//   at the first match, then finish; a check in disabled mode or of an empty image skips the scan
// throughput: one item at a time, busy low again in the result cycle; receiver cannot stall
// reset: synchronous active low; mode to audit, counters and fill count clear, no ram clear
module trust_allowlist_table_core #(
    parameter int TABLE_DEPTH = tat_pkg::TAT_TABLE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // command transfer
    input  logic          start,
    output logic          busy,
    input  tat_pkg::t_cmd i_cmd,
    // result transfer, one cycle strobe
    output logic          o_res_valid,
    output tat_pkg::t_res o_res,
    // mode register write channel
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [1:0]    i_cfg_data
);

    import tat_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int EW = $bits(t_entry);

    // control state
    t_state         r_state, n_state;
    logic [1:0]     r_mode;
    logic [31:0]    r_checks, n_checks;
    logic [31:0]    r_denials, n_denials;
    // slots are never freed, so used slots are always 0 .. r_fill-1
    logic [CW-1:0]  r_fill, n_fill;
    logic [CW-1:0]  r_idx, n_idx;
    logic           r_rd_vld, n_rd_vld;
    logic           r_hit, n_hit;
    logic           r_res_valid, n_res_valid;

    // payload
    t_cmd           r_cmd, n_cmd;
    logic [AW-1:0]  r_cmp_idx, n_cmp_idx;
    logic [AW-1:0]  r_slot, n_slot;
    t_entry         r_hit_entry, n_hit_entry;
    t_res           r_res, n_res;

    // entry ram
    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    t_entry         ram_wdata;
    logic           ram_re;
    t_entry         ram_rdata;

    logic [255:0]   cmd_key;
    logic           key_match;

    tat_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_DEPTH)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign cmd_key   = {r_cmd.key_word0, r_cmd.key_word1, r_cmd.key_word2, r_cmd.key_word3};
    // compare stage works on the registered read data, in the cycle after its read address
    assign key_match = r_rd_vld && (ram_rdata.key == cmd_key);

    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mode      <= MODE_AUDIT;
            r_checks    <= '0;
            r_denials   <= '0;
            r_fill      <= '0;
            r_idx       <= '0;
            r_rd_vld    <= 1'b0;
            r_hit       <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_checks    <= n_checks;
            r_denials   <= n_denials;
            r_fill      <= n_fill;
            r_idx       <= n_idx;
            r_rd_vld    <= n_rd_vld;
            r_hit       <= n_hit;
            r_res_valid <= n_res_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_mode <= i_cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_cmp_idx   <= n_cmp_idx;
        r_slot      <= n_slot;
        r_hit_entry <= n_hit_entry;
        r_res       <= n_res;
    end

    // sequencer: accept, scan slots one per cycle, then resolve and write back
    always_comb begin
        n_state     = r_state;
        n_checks    = r_checks;
        n_denials   = r_denials;
        n_fill      = r_fill;
        n_idx       = r_idx;
        n_rd_vld    = 1'b0;
        n_hit       = r_hit;
        n_res_valid = 1'b0;
        n_cmd       = r_cmd;
        n_cmp_idx   = r_cmp_idx;
        n_slot      = r_slot;
        n_hit_entry = r_hit_entry;
        n_res       = r_res;
        ram_we      = 1'b0;
        ram_waddr   = r_slot;
        ram_wdata   = '{key: cmd_key, trust: r_cmd.trust_in, flags: r_cmd.flags_in};
        ram_re      = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_cmd = i_cmd;
                    n_idx = '0;
                    n_hit = 1'b0;
                    // checks that never look at the table skip the scan
                    if (i_cmd.func == FUNC_CHECK &&
                        (r_mode == MODE_DISABLED || i_cmd.image_empty)) begin
                        n_state = ST_FINISH;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end

            ST_SCAN: begin
                priority if (key_match) begin
                    // first matching slot wins
                    n_hit       = 1'b1;
                    n_slot      = r_cmp_idx;
                    n_hit_entry = ram_rdata;
                    n_state     = ST_FINISH;
                end else if (r_idx != r_fill) begin
                    ram_re    = 1'b1;
                    n_cmp_idx = r_idx[AW-1:0];
                    n_rd_vld  = 1'b1;
                    n_idx     = r_idx + CW'(1);
                end else begin
                    // every filled slot compared, no match
                    n_hit   = 1'b0;
                    n_state = ST_FINISH;
                end
            end

            ST_FINISH: begin
                n_res.valid_res   = 1'b0;
                n_res.trust_out   = 2'd0;
                n_res.flags_out   = '0;
                n_res.trusted     = 1'b0;
                n_res.status      = STAT_OK;

                unique case (r_cmd.func)
                    FUNC_CHECK: begin
                        if (r_mode == MODE_DISABLED) begin
                            n_res.valid_res = 1'b1;
                            n_res.trust_out = LVL_UNTRUSTED;
                        end else begin
                            n_checks = r_checks + 32'd1;
                            if (r_cmd.image_empty) begin
                                // empty image is rejected but not counted as a denial
                                n_res.trust_out = LVL_UNTRUSTED;
                            end else if (r_hit) begin
                                n_res.trust_out = r_hit_entry.trust;
                                n_res.flags_out = r_hit_entry.flags;
                                if (r_hit_entry.trust == LVL_REVOKED) begin
                                    n_denials = r_denials + 32'd1;
                                end else begin
                                    n_res.valid_res = 1'b1;
                                end
                            end else begin
                                // unknown image: blocked only when enforcing
                                n_res.trust_out = LVL_UNTRUSTED;
                                if (r_mode == MODE_ENFORCE) begin
                                    n_denials = r_denials + 32'd1;
                                end else begin
                                    n_res.valid_res = 1'b1;
                                end
                            end
                        end
                    end

                    FUNC_REGISTER: begin
                        if (r_hit) begin
                            ram_we    = 1'b1;
                            ram_waddr = r_slot;
                        end else if (r_fill != CW'(TABLE_DEPTH)) begin
                            ram_we    = 1'b1;
                            ram_waddr = r_fill[AW-1:0];
                            n_fill    = r_fill + CW'(1);
                        end else begin
                            n_res.status = STAT_FULL;
                        end
                    end

                    FUNC_REVOKE: begin
                        if (r_hit) begin
                            ram_we    = 1'b1;
                            ram_waddr = r_slot;
                            ram_wdata = '{key: cmd_key, trust: LVL_REVOKED,
                                          flags: r_hit_entry.flags};
                        end else begin
                            n_res.status = STAT_NOT_FOUND;
                        end
                    end

                    FUNC_LOOKUP: begin
                        if (r_hit) begin
                            n_res.trust_out = r_hit_entry.trust;
                            n_res.flags_out = r_hit_entry.flags;
                            n_res.trusted   = (r_hit_entry.trust == LVL_SYSTEM) ||
                                              (r_hit_entry.trust == LVL_DEVELOPER);
                        end else begin
                            n_res.trust_out = LVL_UNTRUSTED;
                            n_res.status    = STAT_NOT_FOUND;
                        end
                    end

                    default: begin
                        n_res.status = STAT_OK;
                    end
                endcase

                n_res.checks_done = n_checks;
                n_res.denials     = n_denials;
                n_res_valid       = 1'b1;
                n_state           = ST_IDLE;
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/tat_ram.sv @@
// tat_ram: generic single write port, single read port ram, registered read
// no dependencies
module tat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
